/* design/pmt_ca_system_scanner_unit_assert.svh */
// ----------------------------------------------------------------------------
// PMT CA-system scanner assertion macros
// Short forms of the concurrent assertions used by the port checker.
// They expect signals named clk and rst in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef PMT_CA_SYSTEM_SCANNER_UNIT_ASSERT_SVH
`define PMT_CA_SYSTEM_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PMTCA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmtca assertion failed");

// Next-cycle implication, off while reset is high.
`define PMTCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmtca assertion failed");

// Checks what a reset cycle leaves behind.
`define PMTCA_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pmtca assertion failed");

`endif

/* design/pmtca_pkg.sv */
// ----------------------------------------------------------------------------
// PMT CA-system scanner package
// Shared constants, types and the CA family lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package pmtca_pkg;

  // Largest section the scanner stores a result for.
  localparam int MAX_SECTION_BYTES = 1024;

  // Width of all byte positions; the offset and loop length position saturate.
  localparam int POS_W = 13;
  // One more bit for sums of a position and a small offset.
  localparam int CMP_W = POS_W + 1;

  localparam logic [POS_W-1:0] POS_LIMIT      = '1;
  localparam logic [POS_W-1:0] MAX_END        = POS_W'(MAX_SECTION_BYTES);
  localparam logic [POS_W-1:0] LOOP_START_POS = POS_W'(10);

  localparam logic [7:0] CA_TAG      = 8'h09;
  localparam logic [7:0] NIBBLE_MASK = 8'h0f;

  localparam int FLAG_W = 11;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_SCAN = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [7:0] section_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic              emit;
    logic [FLAG_W-1:0] ca_flags;
    logic              too_long;
  } result_t;

  // Maps the first CA-system-ID byte to its family flag.
  function automatic logic [FLAG_W-1:0] family_bit(input logic [7:0] id);
    logic [FLAG_W-1:0] bits;
    bits = '0;
    case (id)
      8'h06:   bits[0]  = 1'b1;
      8'h17:   bits[1]  = 1'b1;
      8'h01:   bits[2]  = 1'b1;
      8'h05:   bits[3]  = 1'b1;
      8'h18:   bits[4]  = 1'b1;
      8'h0B:   bits[5]  = 1'b1;
      8'h0D:   bits[6]  = 1'b1;
      8'h09:   bits[7]  = 1'b1;
      8'h26:   bits[8]  = 1'b1;
      8'h4a:   bits[9]  = 1'b1;
      8'h0E:   bits[10] = 1'b1;
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

/* design/pmtca_apb_regs.sv */
// ----------------------------------------------------------------------------
// PMT CA-system scanner register file
// APB-style access to the scan-in-progress register.
// ----------------------------------------------------------------------------
`default_nettype none

module pmtca_apb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pmtca_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pmtca_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pmtca_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready,
  output logic                                  scan_in_progress
);
  import pmtca_pkg::*;

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // Registers sit on 32-bit words; the word index picks the register.
  assign reg_sel = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_in_progress <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SCAN: scan_in_progress <= pwdata[0];
        default:  scan_in_progress <= scan_in_progress;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SCAN: prdata[0] = scan_in_progress;
      default:  prdata    = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/pmtca_parse_core.sv */
// ----------------------------------------------------------------------------
// PMT CA-system scanner parse core
// Holds the section parse state and works out one byte in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pmtca_parse_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire pmtca_pkg::item_t   item,
  input  wire logic               scan_in_progress,
  output pmtca_pkg::result_t      result
);
  import pmtca_pkg::*;

  // Parse state.
  logic [POS_W-1:0]  byte_offset;
  logic [POS_W-1:0]  section_end;
  logic [POS_W-1:0]  loop_length_pos;
  logic [POS_W-1:0]  loop_end_pos;
  logic [POS_W-1:0]  next_descriptor_pos;
  logic [3:0]        length_high_nibble;
  logic              descriptor_is_ca;
  logic [FLAG_W-1:0] found_flags;

  logic [POS_W-1:0]  byte_offset_next;
  logic [POS_W-1:0]  section_end_next;
  logic [POS_W-1:0]  loop_length_pos_next;
  logic [POS_W-1:0]  loop_end_pos_next;
  logic [POS_W-1:0]  next_descriptor_pos_next;
  logic [3:0]        length_high_nibble_next;
  logic              descriptor_is_ca_next;
  logic [FLAG_W-1:0] found_flags_next;

  // State as seen by this byte, after a restart mark is applied.
  logic [POS_W-1:0]  bo;
  logic [POS_W-1:0]  se;
  logic [POS_W-1:0]  llp;
  logic [POS_W-1:0]  lep;
  logic [POS_W-1:0]  ndp;
  logic [3:0]        lhn;
  logic              dca;
  logic [FLAG_W-1:0] ff;

  logic [7:0]        b;
  logic [CMP_W-1:0]  o_w;
  logic [CMP_W-1:0]  se_w;
  logic [POS_W-1:0]  cut;
  logic [POS_W-1:0]  cut_new;
  logic              skip;
  logic              walking;
  logic [CMP_W-1:0]  loop_end;
  logic [CMP_W-1:0]  llp_sum;

  always_comb begin
    b   = item.section_byte;
    bo  = item.first_byte ? '0             : byte_offset;
    se  = item.first_byte ? '0             : section_end;
    llp = item.first_byte ? LOOP_START_POS : loop_length_pos;
    lep = item.first_byte ? '0             : loop_end_pos;
    ndp = item.first_byte ? '0             : next_descriptor_pos;
    lhn = item.first_byte ? '0             : length_high_nibble;
    dca = item.first_byte ? 1'b0           : descriptor_is_ca;
    ff  = item.first_byte ? '0             : found_flags;

    byte_offset_next         = (bo != POS_LIMIT) ? bo + POS_W'(1) : bo;
    section_end_next         = se;
    loop_length_pos_next     = llp;
    loop_end_pos_next        = lep;
    next_descriptor_pos_next = ndp;
    length_high_nibble_next  = lhn;
    descriptor_is_ca_next    = dca;
    found_flags_next         = ff;

    o_w      = {1'b0, bo};
    se_w     = '0;
    loop_end = '0;
    llp_sum  = '0;
    walking  = 1'b0;
    cut_new  = '0;
    result   = '0;

    // Bytes at or past the (capped) section end are ignored. An unknown
    // end (zero) never cuts.
    cut  = (se > MAX_END) ? MAX_END : se;
    skip = (bo >= POS_W'(3)) && (cut != '0) && (bo >= cut);

    if (!skip) begin
      // Section length from bytes one and two.
      if (bo == POS_W'(1)) begin
        length_high_nibble_next = 4'(b & NIBBLE_MASK);
      end else if (bo == POS_W'(2)) begin
        section_end_next = POS_W'({lhn, b}) + POS_W'(3);
      end
      se_w = {1'b0, section_end_next};

      // Descriptor walk: tag, then length, then the first ID byte.
      walking = ndp < lep;
      if (walking && (bo == ndp)) begin
        descriptor_is_ca_next = (b == CA_TAG) && ((o_w + CMP_W'(4)) < se_w);
      end else if (walking && (o_w == ({1'b0, ndp} + CMP_W'(1)))) begin
        next_descriptor_pos_next = POS_W'(o_w + CMP_W'(1) + CMP_W'(b));
        if (b == 8'h00) begin
          descriptor_is_ca_next = 1'b0;
        end
      end else if (dca) begin
        if (!scan_in_progress) begin
          found_flags_next = ff | family_bit(b);
        end
        descriptor_is_ca_next = 1'b0;
      end

      // Loop length chain: high nibble, then low byte of each loop length.
      if ((bo >= LOOP_START_POS) && (bo == llp) && ((o_w + CMP_W'(2)) < se_w)) begin
        length_high_nibble_next = 4'(b & NIBBLE_MASK);
      end else if ((bo >= LOOP_START_POS) && (o_w == ({1'b0, llp} + CMP_W'(1)))
                   && ((o_w + CMP_W'(1)) < se_w)) begin
        loop_end                 = o_w + CMP_W'(1) + CMP_W'({length_high_nibble_next, b});
        loop_end_pos_next        = POS_W'(loop_end);
        next_descriptor_pos_next = POS_W'(o_w + CMP_W'(1));
        llp_sum                  = loop_end + CMP_W'(3);
        loop_length_pos_next     = (llp_sum > {1'b0, POS_LIMIT}) ? POS_LIMIT
                                                                 : POS_W'(llp_sum);
      end

      // Last byte of the section, or of the stored part of it.
      cut_new = (section_end_next > MAX_END) ? MAX_END : section_end_next;
      if ((bo >= POS_W'(2)) && (cut_new != '0) && (bo == cut_new - POS_W'(1))) begin
        result.emit     = 1'b1;
        result.ca_flags = scan_in_progress ? '0 : found_flags_next;
        result.too_long = section_end_next > MAX_END;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset         <= '0;
      section_end         <= '0;
      loop_length_pos     <= LOOP_START_POS;
      loop_end_pos        <= '0;
      next_descriptor_pos <= '0;
      length_high_nibble  <= '0;
      descriptor_is_ca    <= 1'b0;
      found_flags         <= '0;
    end else if (fire) begin
      byte_offset         <= byte_offset_next;
      section_end         <= section_end_next;
      loop_length_pos     <= loop_length_pos_next;
      loop_end_pos        <= loop_end_pos_next;
      next_descriptor_pos <= next_descriptor_pos_next;
      length_high_nibble  <= length_high_nibble_next;
      descriptor_is_ca    <= descriptor_is_ca_next;
      found_flags         <= found_flags_next;
    end
  end

endmodule

`default_nettype wire

/* design/pmt_ca_system_scanner_unit.sv */
// Throughput: one byte per cycle unless stalled, set by the single-pass core.
// The input stage stalls only while a finished result waits to be taken.
// Reset (synchronous, active high) empties both stages, clears the parse
// state so the next byte counts as offset zero, and clears the scan register.
// ----------------------------------------------------------------------------
// PMT CA-system scanner top level
// Scans a program map section byte by byte and reports the CA families it
// names, one result per section at its last stored byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_ca_system_scanner_unit (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  // Configuration port.
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic [pmtca_pkg::APB_ADDR_W-1:0]         paddr,
  input  wire logic [pmtca_pkg::APB_DATA_W-1:0]         pwdata,
  output logic      [pmtca_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                          pready,
  // Section bytes in.
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic [7:0]                               section_byte,
  input  wire logic                                     first_byte,
  // Results out.
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic      [pmtca_pkg::FLAG_W-1:0]             ca_flags,
  output logic                                          too_long
);
  import pmtca_pkg::*;

  logic    scan_in_progress;

  // Input register: holds one byte ahead of the parse core.
  logic    s1_valid;
  item_t   s1_item;

  logic    out_free;
  logic    advance;
  logic    in_accept;
  result_t core_result;

  pmtca_apb_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .scan_in_progress (scan_in_progress)
  );

  // The result register is free when empty or when its item is taken now.
  // A byte leaves the input register into the parse core only then, so a
  // result is never overwritten; bytes that produce no result flow too.
  assign out_free  = !out_valid || !out_stall;
  assign advance   = s1_valid && out_free;
  assign in_stall  = s1_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.section_byte <= section_byte;
      s1_item.first_byte   <= first_byte;
    end
  end

  // Parse state steps once for every byte that leaves the input register.
  pmtca_parse_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .item             (s1_item),
    .scan_in_progress (scan_in_progress),
    .result           (core_result)
  );

  // Result register: loaded only on the last stored byte of a section.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && core_result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_result.emit) begin
      ca_flags <= core_result.ca_flags;
      too_long <= core_result.too_long;
    end
  end

endmodule

`default_nettype wire

/* design/pmtca_checker.sv */
// ----------------------------------------------------------------------------
// PMT CA-system scanner port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pmt_ca_system_scanner_unit_assert.svh"

module pmtca_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             psel,
  input wire logic                             penable,
  input wire logic                             pwrite,
  input wire logic [pmtca_pkg::APB_ADDR_W-1:0] paddr,
  input wire logic [pmtca_pkg::APB_DATA_W-1:0] pwdata,
  input wire logic [pmtca_pkg::APB_DATA_W-1:0] prdata,
  input wire logic                             pready,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [7:0]                       section_byte,
  input wire logic                             first_byte,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [pmtca_pkg::FLAG_W-1:0]     ca_flags,
  input wire logic                             too_long
);

  // A waiting result keeps its value until it is taken.
  `PMTCA_ASSERT_NEXT(a_result_holds, out_valid && out_stall,
    out_valid && $stable(ca_flags) && $stable(too_long))

  // A stalled input item stays offered with the same payload.
  `PMTCA_ASSERT_NEXT(a_input_holds, in_valid && in_stall,
    in_valid && $stable(section_byte) && $stable(first_byte))

  // The input side only backs up behind a result that is itself held.
  `PMTCA_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall)

  // A write to the scan register reads back on the next cycle.
  `PMTCA_ASSERT_NEXT(a_scan_readback, psel && penable && pwrite && pready && !paddr[2],
    prdata[0] == $past(pwdata[0]))

  // Reset leaves no result pending.
  `PMTCA_ASSERT_RESET(a_reset_empty, !out_valid)

endmodule

bind pmt_ca_system_scanner_unit pmtca_checker u_checker (.*);

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// PMT CA-system scanner testbench
// Streams program map sections into the scanner, one item per byte, and
// checks every result against a cycle-free model of the section parser kept
// in this file. Directed sections cover the CA families, the loop and
// descriptor corner cases, oversize sections and the scan register; a short
// random run follows, with random idling on both sides.
// ----------------------------------------------------------------------------

module tb;
  import pmtca_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // longest quiet stretch of a correct run is the receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 2000;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_OFF_CYCLES = 300;
  // Settling time allowed after the last expected result has been taken.
  localparam int DRAIN_CYCLES = 6;
  // The directed tests already send well over two thousand items, most of
  // them in the two section-size boundary cases.
  localparam int RANDOM_ITEMS = 300;

  // Expected content of one section result.
  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic              too_long;
  } section_verdict_t;

  logic clk = 1'b0;
  logic rst;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic              in_valid;
  logic              in_stall;
  logic [7:0]        section_byte;
  logic              first_byte;
  logic              out_valid;
  logic              out_stall;
  logic [FLAG_W-1:0] ca_flags;
  logic              too_long;

  pmt_ca_system_scanner_unit dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .section_byte(section_byte),
    .first_byte(first_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ca_flags(ca_flags),
    .too_long(too_long)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Section parser model. It mirrors the scanner's parse state and is stepped
  // once for every byte the block accepts. Sums are formed in 32 bits so that
  // none wraps before a compare; stored positions are cut to the 13-bit width.
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]  pos_count;      // offset of the next byte
  logic [POS_W-1:0]  sect_end;       // declared section size in bytes
  logic [POS_W-1:0]  loop_len_at;    // offset of the next 12-bit loop length
  logic [POS_W-1:0]  loop_stop;      // first offset past the current loop
  logic [POS_W-1:0]  desc_at;        // offset of the next descriptor tag
  logic [3:0]        len_nibble;     // high nibble of a length in flight
  logic              in_ca_desc;     // next non-structural byte is a CA ID
  logic [FLAG_W-1:0] families_seen;
  logic              scan_active;    // mirror of the scan register

  section_verdict_t expected_verdicts[$];
  int unsigned      mismatch_count;

  // The eleven CA-system ID bytes, in flag bit order.
  function automatic logic [7:0] ca_id_of(input int idx);
    case (idx)
      0:       return 8'h06;
      1:       return 8'h17;
      2:       return 8'h01;
      3:       return 8'h05;
      4:       return 8'h18;
      5:       return 8'h0B;
      6:       return 8'h0D;
      7:       return 8'h09;
      8:       return 8'h26;
      9:       return 8'h4a;
      default: return 8'h0E;
    endcase
  endfunction

  function automatic logic [FLAG_W-1:0] family_flag(input logic [7:0] id);
    logic [FLAG_W-1:0] hit;
    hit = '0;
    for (int i = 0; i < FLAG_W; i++)
      if (ca_id_of(i) == id) hit[i] = 1'b1;
    return hit;
  endfunction

  function automatic void clear_parse_state();
    pos_count     = '0;
    sect_end      = '0;
    loop_len_at   = LOOP_START_POS;
    loop_stop     = '0;
    desc_at       = '0;
    len_nibble    = '0;
    in_ca_desc    = 1'b0;
    families_seen = '0;
  endfunction

  // Steps the parser over one byte. Returns 1 when that byte closes the
  // section, with the verdict the block must report for it.
  function automatic bit predict_pmt_byte(input logic [7:0] b, input logic mark,
                                          output section_verdict_t verdict);
    int unsigned o, cut, len, nxt;
    bit          walking;
    verdict = '0;
    if (mark) clear_parse_state();

    o = 32'(pos_count);
    if (pos_count < POS_LIMIT) pos_count = pos_count + 1'b1;

    // Bytes past the end of the section are dropped without a result.
    cut = (sect_end > MAX_SECTION_BYTES) ? MAX_SECTION_BYTES : 32'(sect_end);
    if (o >= 3 && o > cut - 1) return 0;

    if (o == 1)
      len_nibble = 4'(b & NIBBLE_MASK);
    else if (o == 2)
      sect_end = POS_W'((32'(len_nibble) << 8) + 32'(b) + 3);

    // Descriptor walk: tag, then length, then the first body byte, which
    // for a CA descriptor is the CA-system ID byte.
    walking = desc_at < loop_stop;
    if (walking && o == desc_at) begin
      in_ca_desc = (b == CA_TAG) && (o + 4 < sect_end);
    end else if (walking && o == desc_at + 1) begin
      desc_at = POS_W'(o + 1 + b);
      if (b == 8'h00) in_ca_desc = 1'b0;
    end else if (in_ca_desc) begin
      if (!scan_active) families_seen = families_seen | family_flag(b);
      in_ca_desc = 1'b0;
    end

    // Loop length chain: program info loop first, then one per stream entry.
    if (o >= 10 && o == loop_len_at && o + 2 < sect_end) begin
      len_nibble = 4'(b & NIBBLE_MASK);
    end else if (o >= 10 && o == loop_len_at + 1 && o + 1 < sect_end) begin
      len       = (32'(len_nibble) << 8) | 32'(b);
      loop_stop = POS_W'(o + 1 + len);
      desc_at   = POS_W'(o + 1);
      nxt       = 32'(loop_stop) + 3;
      loop_len_at = (nxt > POS_LIMIT) ? POS_LIMIT : POS_W'(nxt);
    end

    if (o >= 2) begin
      cut = (sect_end > MAX_SECTION_BYTES) ? MAX_SECTION_BYTES : 32'(sect_end);
      if (o == cut - 1) begin
        verdict.flags    = scan_active ? '0 : families_seen;
        verdict.too_long = sect_end > MAX_SECTION_BYTES;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
  endfunction

  // Both channels are observed at the rising edge, before the block's own
  // registers update. Every accepted byte steps the model; every accepted
  // result is matched against the oldest verdict still waiting.
  always @(posedge clk) begin : observe
    section_verdict_t got_verdict;
    section_verdict_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        if (predict_pmt_byte(section_byte, first_byte, got_verdict))
          expected_verdicts.push_back(got_verdict);
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          note_mismatch("result with no section ended", 0, 32'({ca_flags, too_long}));
        end else begin
          want = expected_verdicts.pop_front();
          if (ca_flags !== want.flags)
            note_mismatch("ca_flags", 32'(want.flags), 32'(ca_flags));
          if (too_long !== want.too_long)
            note_mismatch("too_long", 32'(want.too_long), 32'(too_long));
        end
      end
    end
  end

  // Hang detection: counts cycles in which neither channel moves an item.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. For every result it draws a stall length; when that is
  // nonzero, stall is held while waiting for the result and for that many
  // cycles after it shows up, so the block sits with a finished result and
  // must stall its input. A hold-off request stalls it for a long stretch.
  // --------------------------------------------------------------------------
  int unsigned out_gap_max = 0;
  int unsigned receiver_hold = 0;

  initial begin : receiver
    int unsigned stall_n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (receiver_hold != 0) begin
        out_stall = 1'b1;
        repeat (receiver_hold) @(negedge clk);
        receiver_hold = 0;
      end
      stall_n = $urandom_range(0, out_gap_max);
      if (stall_n != 0) begin
        out_stall = 1'b1;
        do @(posedge clk); while (!out_valid && receiver_hold == 0);
        repeat (stall_n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid && receiver_hold == 0);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. Every task here starts and ends at a falling edge.
  // --------------------------------------------------------------------------
  int unsigned in_gap_max = 0;

  task automatic send_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    section_byte = b;
    first_byte   = mark;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every result has come back and the last bytes have left
  // the pipeline, so the block is idle afterwards.
  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write of the scan register: setup cycle, then access cycle.
  task automatic write_scan_register(input logic value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_ADDR_W'(4 * REG_SCAN);
    pwdata  = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    scan_active = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Section builder. Lengths are patched once the loop or section is closed.
  // --------------------------------------------------------------------------
  logic [7:0] pmt_bytes[$];

  function automatic void open_section();
    pmt_bytes.delete();
    pmt_bytes.push_back(8'h02);
    pmt_bytes.push_back(8'hB0);
    pmt_bytes.push_back(8'h00);
    // Program number, version, section numbers and PCR PID.
    repeat (7) pmt_bytes.push_back(8'($urandom));
  endfunction

  function automatic int open_loop();
    int at;
    at = pmt_bytes.size();
    pmt_bytes.push_back(8'hF0);
    pmt_bytes.push_back(8'h00);
    return at;
  endfunction

  function automatic void close_loop(input int at);
    int len;
    len = pmt_bytes.size() - at - 2;
    pmt_bytes[at]     = 8'hF0 | 8'((len >> 8) & 'hF);
    pmt_bytes[at + 1] = 8'(len);
  endfunction

  function automatic void add_stream(input logic [7:0] kind);
    pmt_bytes.push_back(kind);
    pmt_bytes.push_back(8'hE1);
    pmt_bytes.push_back(8'($urandom));
  endfunction

  // Appends a descriptor; lead is its first body byte (the CA ID for tag 0x09).
  function automatic void add_descriptor(input logic [7:0] tag, input logic [7:0] lead,
                                         input int len);
    pmt_bytes.push_back(tag);
    pmt_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++)
      pmt_bytes.push_back((i == 0) ? lead : 8'($urandom));
  endfunction

  // Appends the CRC and fills in the section length.
  function automatic void close_section();
    int len;
    repeat (4) pmt_bytes.push_back(8'($urandom));
    len = pmt_bytes.size() - 3;
    pmt_bytes[1] = 8'hB0 | 8'((len >> 8) & 'hF);
    pmt_bytes[2] = 8'(len);
  endfunction

  function automatic logic [7:0] pick_ca_id();
    if ($urandom_range(0, 4) != 0) return ca_id_of($urandom_range(0, FLAG_W - 1));
    return 8'($urandom);
  endfunction

  function automatic void add_random_descriptor();
    logic [7:0] tag;
    tag = $urandom_range(0, 1) ? CA_TAG : 8'($urandom);
    add_descriptor(tag, pick_ca_id(), $urandom_range(0, 6));
  endfunction

  // A well-formed section with random descriptors and stream entries.
  function automatic void build_random_section();
    int at;
    open_section();
    at = open_loop();
    repeat ($urandom_range(0, 3)) add_random_descriptor();
    close_loop(at);
    repeat ($urandom_range(0, 3)) begin
      add_stream(8'($urandom));
      at = open_loop();
      repeat ($urandom_range(0, 2)) add_random_descriptor();
      close_loop(at);
    end
    close_section();
  endfunction

  // CA descriptors in both the program info loop and one stream loop.
  // Returns the offset where the stream entry starts.
  function automatic int build_two_loop_section();
    int at, split;
    open_section();
    at = open_loop();
    add_descriptor(CA_TAG, 8'h0B, 4);
    add_descriptor(CA_TAG, 8'h26, 4);
    close_loop(at);
    split = pmt_bytes.size();
    add_stream(8'h1B);
    at = open_loop();
    add_descriptor(CA_TAG, 8'h18, 4);
    add_descriptor(CA_TAG, 8'h05, 2);
    close_loop(at);
    close_section();
    return split;
  endfunction

  // Sends bytes [from, upto) of the built section; the mark goes on offset 0.
  task automatic send_part(input int from, input int upto, input logic mark);
    for (int i = from; i < upto; i++)
      send_byte(pmt_bytes[i], mark && i == 0);
  endtask

  task automatic send_section();
    send_part(0, pmt_bytes.size(), 1'b1);
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 5;
      default: return 16;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset the first byte is offset zero even without the mark.
  task automatic test_unmarked_start();
    int at;
    open_section();
    at = open_loop();
    add_descriptor(CA_TAG, 8'h06, 4);
    close_loop(at);
    add_stream(8'h02);
    at = open_loop();
    add_descriptor(CA_TAG, 8'h4a, 4);
    close_loop(at);
    close_section();
    send_part(0, pmt_bytes.size(), 1'b0);
    wait_results_drained();
  endtask

  // Every listed CA family, an unknown ID, a zero-length CA descriptor and a
  // non-CA descriptor whose body starts with a listed ID.
  task automatic test_ca_families();
    int at;
    in_gap_max  = 2;
    out_gap_max = 2;
    open_section();
    at = open_loop();
    for (int i = 0; i < FLAG_W; i++) add_descriptor(CA_TAG, ca_id_of(i), 4);
    close_loop(at);
    close_section();
    send_section();
    open_section();
    at = open_loop();
    add_descriptor(CA_TAG, 8'h42, 4);
    add_descriptor(CA_TAG, 8'h06, 0);
    add_descriptor(8'h0A, 8'h4a, 2);
    close_loop(at);
    close_section();
    send_section();
    wait_results_drained();
  endtask

  // Shortest sections, bytes at both extremes, stray bytes after a section
  // and a section cut short by the next marked byte.
  task automatic test_field_extremes();
    pmt_bytes = '{8'h00, 8'h00, 8'h00};
    send_section();
    // Trailing bytes after the last one are ignored until the next mark.
    repeat (3) send_byte(8'hFF, 1'b0);
    pmt_bytes = '{8'hFF, 8'hB0, 8'h00};
    send_section();
    void'(build_two_loop_section());
    send_part(0, 12, 1'b1);
    void'(build_two_loop_section());
    send_section();
    wait_results_drained();
  endtask

  // Loop and descriptor corner cases.
  task automatic test_loop_edges();
    int at;
    // A CA descriptor that runs past its loop: its ID byte is the stream
    // type of the next entry, so that byte plays both roles.
    open_section();
    pmt_bytes.push_back(8'hF0);
    pmt_bytes.push_back(8'h02);
    pmt_bytes.push_back(CA_TAG);
    pmt_bytes.push_back(8'h04);
    add_stream(8'h06);
    at = open_loop();
    add_descriptor(CA_TAG, 8'h0E, 4);
    close_loop(at);
    close_section();
    send_section();
    // A CA tag inside the CRC does not count.
    open_section();
    pmt_bytes.push_back(8'hF0);
    pmt_bytes.push_back(8'h04);
    close_section();
    pmt_bytes[12] = CA_TAG;
    pmt_bytes[13] = 8'h02;
    pmt_bytes[14] = 8'h06;
    pmt_bytes[15] = 8'h00;
    send_section();
    // A program info loop that claims more than the section holds: no later
    // loop length is followed.
    void'(build_two_loop_section());
    pmt_bytes[10] = 8'hF3;
    pmt_bytes[11] = 8'hFF;
    send_section();
    wait_results_drained();
  endtask

  // A section longer than the store is reported at its bound with too_long
  // set; one that fits exactly is not.
  task automatic test_oversize();
    int at;
    in_gap_max  = 1;
    out_gap_max = 16;
    open_section();
    at = open_loop();
    add_descriptor(CA_TAG, 8'h17, 4);
    while (pmt_bytes.size() < MAX_SECTION_BYTES + 6) pmt_bytes.push_back(8'($urandom));
    pmt_bytes[1]  = 8'hBF;
    pmt_bytes[2]  = 8'hFF;
    pmt_bytes[10] = 8'hFF;
    pmt_bytes[11] = 8'hFF;
    send_section();
    open_section();
    at = open_loop();
    add_descriptor(CA_TAG, 8'h0D, 4);
    while (pmt_bytes.size() < MAX_SECTION_BYTES - 4) pmt_bytes.push_back(8'($urandom));
    close_loop(at);
    close_section();
    send_section();
    wait_results_drained();
  endtask

  // The scan register suppresses flag collection, over whole sections and
  // over part of one, and zeroes the result when set at the last byte.
  task automatic test_scan_register();
    int split;
    in_gap_max  = 3;
    out_gap_max = 3;
    split = build_two_loop_section();
    write_scan_register(1'b1);
    send_section();
    wait_results_drained();
    write_scan_register(1'b0);
    send_section();
    wait_results_drained();
    // Scan starts after the program info loop: result must read zero.
    send_part(0, split, 1'b1);
    wait_results_drained();
    write_scan_register(1'b1);
    send_part(split, pmt_bytes.size(), 1'b0);
    wait_results_drained();
    // Scan ends after the program info loop: only stream flags survive.
    send_part(0, split, 1'b1);
    wait_results_drained();
    write_scan_register(1'b0);
    send_part(split, pmt_bytes.size(), 1'b0);
    wait_results_drained();
  endtask

  // The receiver holds off for a long stretch while sections keep coming,
  // so the block fills up and stalls its input.
  task automatic test_input_backpressure();
    in_gap_max    = 0;
    out_gap_max   = 0;
    receiver_hold = HOLD_OFF_CYCLES;
    repeat (4) begin
      build_random_section();
      send_section();
    end
    wait_results_drained();
  endtask

  // Mostly well-formed sections with random content; some get a corrupted
  // byte, some are cut short and some are followed by stray bytes. Idling
  // on both sides changes every few sections, and the scan register is
  // rewritten now and then while the block is idle.
  task automatic test_random_sections();
    int unsigned sent, cut, kind, n;
    sent = 0;
    n    = 0;
    while (sent < RANDOM_ITEMS) begin
      if (n % 4 == 0) begin
        in_gap_max  = pick_gap();
        out_gap_max = pick_gap();
      end
      if (n % 5 == 4) begin
        wait_results_drained();
        write_scan_register(1'($urandom_range(0, 1)));
      end
      build_random_section();
      kind = $urandom_range(0, 9);
      cut  = pmt_bytes.size();
      if (kind == 0)
        pmt_bytes[$urandom_range(1, pmt_bytes.size() - 1)] = 8'($urandom);
      else if (kind == 1)
        cut = $urandom_range(1, pmt_bytes.size() - 1);
      send_part(0, cut, 1'b1);
      sent += cut;
      if (kind == 2)
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
      n++;
    end
    wait_results_drained();
    write_scan_register(1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, run the tests in turn, then report.
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    section_byte   = '0;
    first_byte     = 1'b0;
    mismatch_count = 0;
    clear_parse_state();
    scan_active = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_unmarked_start();
    test_ca_families();
    test_field_extremes();
    test_loop_edges();
    test_oversize();
    test_scan_register();
    test_input_backpressure();
    test_random_sections();

    wait_results_drained();
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
